>>> src/plps_pkg.sv
// Shared types, constants and helper functions of the point light shading pipeline.
// No dependencies; every other file but plps_delay imports this package.
`default_nettype none
package plps_pkg;

   localparam int ONE_Q14 = 16384;
   localparam int DIV_LAT = 16;
   localparam int L_CW    = 17;
   localparam int R_CW    = 20;

   localparam logic [2:0] REG_LIGHT_X   = 3'd0;
   localparam logic [2:0] REG_LIGHT_Y   = 3'd1;
   localparam logic [2:0] REG_LIGHT_Z   = 3'd2;
   localparam logic [2:0] REG_CAMERA_X  = 3'd3;
   localparam logic [2:0] REG_CAMERA_Y  = 3'd4;
   localparam logic [2:0] REG_CAMERA_Z  = 3'd5;
   localparam logic [2:0] REG_INTENSITY = 3'd6;
   localparam logic [2:0] REG_COLOR     = 3'd7;

   typedef struct packed {
      logic neg;
      logic zero;
      logic ovf;
   } div_flags_type;

   function automatic logic [14:0] clamp_term(input logic signed [31:0] p);
      logic [17:0] t;
      t = p[31:14];
      if (p <= 32'sd0) begin
         return 15'd0;
      end
      if (t > 18'(ONE_Q14)) begin
         return 15'(ONE_Q14);
      end
      return t[14:0];
   endfunction

endpackage
`default_nettype wire

>>> src/point_light_phong_shading_top.sv
// Point light Phong shading: CSR file, pipeline control and shading arithmetic.
// Uses plps_pkg, plps_delay, plps_unit3 and plps_power.
//
// Usage: each item on req_ carries a Q1.14 surface normal and a Q8.8 position; each
// item on rsp_ carries the Q4.12 red, green and blue contribution of the light.
// Light and camera position, intensity and color are set through the csr_ APB port
// (64-bit data, register i at byte address 8*i) while the pipeline is empty.
// Throughput: one item per clock cycle unless rsp_tready stalls the pipeline.
// The path runs through the two vector normalizers in series (square root and divide
// pipelines, one bit per stage) and the chained specular multiplies.
// Reset clears the CSRs, delay lines and valid bits; no item is in flight afterward.
// When the receiver holds rsp_tready low with a result waiting, the whole pipeline
// holds and req_tready drops; nothing is lost or repeated.
`default_nettype none
module point_light_phong_shading_top
   import plps_pkg::*;
#(
   parameter int LIGHT_RANGE = 20,
   parameter int SHININESS   = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // normal_x, normal_y, normal_z, point_x, point_y, point_z (16 bits each)
   input  wire logic [95:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // red_out, green_out, blue_out (16 bits each)
   output logic [47:0]      rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [5:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic [63:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int LN1 = L_CW + 9;
   localparam int LU1 = 2 + LN1 + DIV_LAT;
   localparam int LU2 = 2 + R_CW + 9 + DIV_LAT;
   localparam int VLAT = 10 + LU1 + LU2 + SHININESS;
   localparam int ATT_YW = 21;
   localparam int ATT_XW = 23;
   localparam int ATT_MW = 23;
   localparam int ATT_SHIFT = ATT_YW + $clog2(LIGHT_RANGE);
   localparam logic [ATT_MW-1:0] ATT_MUL =
      ATT_MW'(((64'd1 << ATT_SHIFT) + 64'(LIGHT_RANGE) - 64'd1) / 64'(LIGHT_RANGE));
   localparam logic [ATT_XW-1:0] RQ = ATT_XW'(LIGHT_RANGE) << 16;

   logic [15:0] pos_ff [6];
   logic [47:0] intensity_ff;
   logic [47:0] color_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 6; k++) begin
            pos_ff[k] <= '0;
         end
         intensity_ff <= '0;
         color_ff     <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_LIGHT_X:   pos_ff[0]    <= csr_pwdata[15:0];
            REG_LIGHT_Y:   pos_ff[1]    <= csr_pwdata[15:0];
            REG_LIGHT_Z:   pos_ff[2]    <= csr_pwdata[15:0];
            REG_CAMERA_X:  pos_ff[3]    <= csr_pwdata[15:0];
            REG_CAMERA_Y:  pos_ff[4]    <= csr_pwdata[15:0];
            REG_CAMERA_Z:  pos_ff[5]    <= csr_pwdata[15:0];
            REG_INTENSITY: intensity_ff <= csr_pwdata[47:0];
            REG_COLOR:     color_ff     <= csr_pwdata[47:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_LIGHT_X:   csr_prdata = {48'd0, pos_ff[0]};
         REG_LIGHT_Y:   csr_prdata = {48'd0, pos_ff[1]};
         REG_LIGHT_Z:   csr_prdata = {48'd0, pos_ff[2]};
         REG_CAMERA_X:  csr_prdata = {48'd0, pos_ff[3]};
         REG_CAMERA_Y:  csr_prdata = {48'd0, pos_ff[4]};
         REG_CAMERA_Z:  csr_prdata = {48'd0, pos_ff[5]};
         REG_INTENSITY: csr_prdata = {16'd0, intensity_ff};
         REG_COLOR:     csr_prdata = {16'd0, color_ff};
         default:       csr_prdata = '0;
      endcase
   end

   logic en;
   logic valid_a_ff;
   logic valid_out;

   assign en         = !valid_out || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = valid_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (en) begin
         valid_a_ff <= req_tvalid;
      end
   end

   plps_delay #(.WIDTH(1), .DEPTH(VLAT)) u_vdly (
      .clock(clock), .reset(reset), .en(en), .d(valid_a_ff), .q(valid_out)
   );

   logic signed [15:0]     n_a_ff  [3];
   logic signed [L_CW-1:0] dl_a_ff [3];
   logic signed [L_CW-1:0] dc_a_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            n_a_ff[k]  <= signed'(req_tdata[16*k +: 16]);
            dl_a_ff[k] <= signed'({pos_ff[k][15], pos_ff[k]})
                        - signed'({req_tdata[16*k+63], req_tdata[16*k+48 +: 16]});
            dc_a_ff[k] <= signed'({pos_ff[k+3][15], pos_ff[k+3]})
                        - signed'({req_tdata[16*k+63], req_tdata[16*k+48 +: 16]});
         end
      end
   end

   logic signed [15:0] l_b [3];
   logic signed [15:0] v_b [3];
   logic [LN1-1:0]     dlen_b;
   logic [L_CW+8:0]    vlen_unused;

   plps_unit3 #(.CW(L_CW)) u_unit_l (
      .clock(clock), .reset(reset), .en(en), .c(dl_a_ff), .u(l_b), .lq(dlen_b)
   );

   plps_unit3 #(.CW(L_CW)) u_unit_v (
      .clock(clock), .reset(reset), .en(en), .c(dc_a_ff), .u(v_b), .lq(vlen_unused)
   );

   logic [47:0] n_a_pack;
   logic [47:0] n_b_pack;
   logic [47:0] n_c_pack;
   logic [47:0] l_b_pack;
   logic [47:0] l_c_pack;
   logic [47:0] v_b_pack;
   logic [47:0] v_e_pack;

   assign n_a_pack = {n_a_ff[2], n_a_ff[1], n_a_ff[0]};
   assign l_b_pack = {l_b[2], l_b[1], l_b[0]};
   assign v_b_pack = {v_b[2], v_b[1], v_b[0]};

   plps_delay #(.WIDTH(48), .DEPTH(LU1)) u_ndly (
      .clock(clock), .reset(reset), .en(en), .d(n_a_pack), .q(n_b_pack)
   );
   plps_delay #(.WIDTH(48), .DEPTH(2)) u_ncdly (
      .clock(clock), .reset(reset), .en(en), .d(n_b_pack), .q(n_c_pack)
   );
   plps_delay #(.WIDTH(48), .DEPTH(3)) u_ldly (
      .clock(clock), .reset(reset), .en(en), .d(l_b_pack), .q(l_c_pack)
   );
   plps_delay #(.WIDTH(48), .DEPTH(4 + LU2)) u_vedly (
      .clock(clock), .reset(reset), .en(en), .d(v_b_pack), .q(v_e_pack)
   );

   logic signed [31:0] nl_prod_ff [3];
   logic signed [31:0] ndl_ff;
   logic [14:0]        diff_c3_ff;
   logic signed [48:0] t_ff [3];
   logic signed [R_CW-1:0] rb_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            nl_prod_ff[k] <= signed'(n_b_pack[16*k +: 16]) * signed'(l_b_pack[16*k +: 16]);
         end
         ndl_ff     <= nl_prod_ff[0] + nl_prod_ff[1] + nl_prod_ff[2];
         diff_c3_ff <= clamp_term(ndl_ff);
         for (int k = 0; k < 3; k++) begin
            t_ff[k] <= (49'(ndl_ff) * 49'(signed'(n_c_pack[16*k +: 16]))) <<< 1;
         end
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_refl
      logic signed [49:0] x_in;
      logic [49:0]        mag_in;
      logic [21:0]        q_in;
      assign x_in   = 50'(t_ff[k]) - (50'(signed'(l_c_pack[16*k +: 16])) <<< 28);
      assign mag_in = x_in[49] ? 50'(-x_in) : 50'(x_in);
      assign q_in   = mag_in[49:28];
      always_ff @(posedge clock) begin
         if (en) begin
            rb_ff[k] <= x_in[49] ? R_CW'(-signed'(q_in)) : R_CW'(q_in);
         end
      end
   end

   logic signed [15:0]  r_d [3];
   logic [R_CW+8:0]     rlen_unused;

   plps_unit3 #(.CW(R_CW)) u_unit_r (
      .clock(clock), .reset(reset), .en(en), .c(rb_ff), .u(r_d), .lq(rlen_unused)
   );

   logic signed [31:0] vr_prod_ff [3];
   logic [14:0]        base_ff;
   logic [14:0]        spec;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            vr_prod_ff[k] <= signed'(v_e_pack[16*k +: 16]) * r_d[k];
         end
         base_ff <= clamp_term(vr_prod_ff[0] + vr_prod_ff[1] + vr_prod_ff[2]);
      end
   end

   plps_power #(.STAGES(SHININESS)) u_power (
      .clock(clock), .en(en), .base(base_ff), .spec(spec)
   );

   logic [ATT_YW-1:0] att_y_ff;
   logic [ATT_YW+ATT_MW-1:0] att_p_ff;
   logic [14:0]       att_q_ff;
   logic [14:0]       att_f;
   logic [14:0]       diff_f;
   logic [ATT_XW-1:0] att_x_in;

   assign att_x_in = RQ - ATT_XW'(dlen_b);

   always_ff @(posedge clock) begin
      if (en) begin
         att_y_ff <= (dlen_b < LN1'(RQ)) ? att_x_in[ATT_XW-1:2] : '0;
         att_p_ff <= att_y_ff * ATT_MUL;
         att_q_ff <= 15'(att_p_ff >> ATT_SHIFT);
      end
   end

   plps_delay #(.WIDTH(15), .DEPTH(4 + LU2 + SHININESS)) u_attdly (
      .clock(clock), .reset(reset), .en(en), .d(att_q_ff), .q(att_f)
   );
   plps_delay #(.WIDTH(15), .DEPTH(3 + LU2 + SHININESS)) u_diffdly (
      .clock(clock), .reset(reset), .en(en), .d(diff_c3_ff), .q(diff_f)
   );

   logic [15:0] str_ff;
   logic [30:0] sa_ff;
   logic [31:0] cc_ff   [3];
   logic [62:0] prod_ff [3];
   logic [15:0] out_ff  [3];

   always_ff @(posedge clock) begin
      if (en) begin
         str_ff <= 16'(diff_f) + 16'(spec);
         sa_ff  <= str_ff * att_f;
         for (int k = 0; k < 3; k++) begin
            cc_ff[k]   <= color_ff[32-16*k +: 16] * intensity_ff[32-16*k +: 16];
            prod_ff[k] <= cc_ff[k] * sa_ff;
            out_ff[k]  <= (prod_ff[k][62:60] != 3'd0) ? 16'hFFFF : prod_ff[k][59:44];
         end
      end
   end

   assign rsp_tdata = {out_ff[2], out_ff[1], out_ff[0]};

endmodule
`default_nettype wire

>>> src/plps_delay.sv
// Enabled shift line that carries payload and valid bits alongside the pipeline.
// Depends on nothing.
`default_nettype none
module plps_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic [WIDTH-1:0] d,
   output logic      [WIDTH-1:0] q
);

   logic [WIDTH-1:0] line_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            line_ff[i] <= '0;
         end
      end else if (en) begin
         line_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign q = line_ff[DEPTH-1];

endmodule
`default_nettype wire

>>> src/plps_div.sv
// Pipelined restoring divider: trunc(c * 2^22 / lq), clamped to +-1.0 in Q1.14.
// Uses plps_pkg; 16 register stages, each between the input and output registers yields one quotient bit.
`default_nettype none
module plps_div
   import plps_pkg::*;
#(
   parameter int CW = 17,
   parameter int LW = 26
) (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic signed [CW-1:0] c,
   input  wire logic        [LW-1:0] lq,
   output logic signed      [15:0]   u
);

   localparam int RW = CW + 22;

   logic [CW-1:0]      mag_in;
   logic [RW-1:0]      rem_ff  [15];
   logic [RW-1:0]      dvs_ff  [15];
   logic [13:0]        quo_ff  [15];
   div_flags_type      flag_ff [15];
   logic signed [15:0] u_ff;
   logic [15:0]        umag_in;

   assign mag_in = c[CW-1] ? CW'(-c) : CW'(c);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= RW'(mag_in) << 22;
         dvs_ff[0]  <= RW'(lq);
         quo_ff[0]  <= '0;
         flag_ff[0] <= '{neg: c[CW-1], zero: (lq == '0), ovf: ((RW'(mag_in) << 8) >= RW'(lq))};
      end
   end

   for (genvar k = 0; k < 14; k++) begin : g_step
      localparam int B = 13 - k;
      logic [RW-1:0] trial;
      assign trial = dvs_ff[k] << B;
      always_ff @(posedge clock) begin
         if (en) begin
            dvs_ff[k+1]  <= dvs_ff[k];
            flag_ff[k+1] <= flag_ff[k];
            if (rem_ff[k] >= trial) begin
               rem_ff[k+1] <= rem_ff[k] - trial;
               quo_ff[k+1] <= quo_ff[k] | (14'd1 << B);
            end else begin
               rem_ff[k+1] <= rem_ff[k];
               quo_ff[k+1] <= quo_ff[k];
            end
         end
      end
   end

   always_comb begin
      if (flag_ff[14].zero) begin
         umag_in = '0;
      end else if (flag_ff[14].ovf) begin
         umag_in = 16'(ONE_Q14);
      end else begin
         umag_in = {2'b00, quo_ff[14]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff <= flag_ff[14].neg ? -signed'(umag_in) : signed'(umag_in);
      end
   end

   assign u = u_ff;

endmodule
`default_nettype wire

>>> src/plps_unit3.sv
// Vector normalizer: squares, pipelined integer square root, three dividers.
// Uses plps_pkg, plps_delay and plps_div.
`default_nettype none
module plps_unit3
   import plps_pkg::*;
#(
   parameter int CW = 17
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic signed [CW-1:0] c  [3],
   output logic signed      [15:0]   u  [3],
   output logic             [CW+8:0] lq
);

   localparam int N   = CW + 9;
   localparam int SW  = 2 * CW + 2;
   localparam int VW  = SW + 16;
   localparam int RMW = N + 2;

   logic [2*CW-1:0] sq_ff [3];
   logic [VW-1:0]   val_ff  [N+1];
   logic [RMW-1:0]  rem_ff  [N+1];
   logic [N-1:0]    root_ff [N+1];
   logic [3*CW-1:0] c_pack;
   logic [3*CW-1:0] c_dly;
   logic signed [CW-1:0] c_d [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            sq_ff[k] <= unsigned'((2*CW)'(c[k]) * (2*CW)'(c[k]));
         end
         val_ff[0]  <= {SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]), 16'd0};
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_sqrt
      logic [RMW-1:0] remx;
      logic [RMW-1:0] trial;
      assign remx  = {rem_ff[i][RMW-3:0], val_ff[i][VW-1:VW-2]};
      assign trial = RMW'({root_ff[i], 2'b01});
      always_ff @(posedge clock) begin
         if (en) begin
            val_ff[i+1] <= val_ff[i] << 2;
            if (remx >= trial) begin
               rem_ff[i+1]  <= remx - trial;
               root_ff[i+1] <= {root_ff[i][N-2:0], 1'b1};
            end else begin
               rem_ff[i+1]  <= remx;
               root_ff[i+1] <= {root_ff[i][N-2:0], 1'b0};
            end
         end
      end
   end

   assign c_pack = {c[2], c[1], c[0]};

   plps_delay #(.WIDTH(3 * CW), .DEPTH(N + 2)) u_cdly (
      .clock(clock), .reset(reset), .en(en), .d(c_pack), .q(c_dly)
   );

   for (genvar k = 0; k < 3; k++) begin : g_div
      assign c_d[k] = signed'(c_dly[k*CW +: CW]);
      plps_div #(.CW(CW), .LW(N)) u_div (
         .clock(clock), .en(en), .c(c_d[k]), .lq(root_ff[N]), .u(u[k])
      );
   end

   plps_delay #(.WIDTH(N), .DEPTH(DIV_LAT)) u_ldly (
      .clock(clock), .reset(reset), .en(en), .d(root_ff[N]), .q(lq)
   );

endmodule
`default_nettype wire

>>> src/plps_power.sv
// Specular power: STAGES chained truncating Q1.14 multiplies, one per stage.
// Uses plps_pkg.
`default_nettype none
module plps_power
   import plps_pkg::*;
#(
   parameter int STAGES = 32
) (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [14:0] base,
   output logic      [14:0] spec
);

   logic [14:0] s_ff [STAGES];
   logic [14:0] b_ff [STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_pow
      logic [14:0] s_prev;
      logic [14:0] b_prev;
      logic [29:0] prod;
      if (i == 0) begin : g_first
         assign s_prev = 15'(ONE_Q14);
         assign b_prev = base;
      end else begin : g_next
         assign s_prev = s_ff[i-1];
         assign b_prev = b_ff[i-1];
      end
      assign prod = s_prev * b_prev;
      always_ff @(posedge clock) begin
         if (en) begin
            s_ff[i] <= prod[28:14];
            b_ff[i] <= b_prev;
         end
      end
   end

   assign spec = s_ff[STAGES-1];

endmodule
`default_nettype wire

>>> tb/point_light_phong_shading_top_tb.sv
// Testbench for point_light_phong_shading_top: streams shading points, predicts each color.
// Depends on plps_pkg and the RTL of the shading pipeline; self-checking, no files read.
`timescale 1ns / 100ps
`default_nettype none
module point_light_phong_shading_top_tb;
   import plps_pkg::*;

   localparam int LIGHT_RANGE = 20;
   localparam int SHININESS   = 32;
   localparam int DRAIN_CYCLES = 200;

   typedef struct packed {
      logic [15:0] blue;
      logic [15:0] green;
      logic [15:0] red;
   } color_type;

   typedef struct packed {
      logic [15:0] nx, ny, nz, px, py, pz;
      logic        typed;
      color_type   color;
   } point_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;   // normal_x, normal_y, normal_z, point_x, point_y, point_z
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // red_out, green_out, blue_out
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [5:0]  csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   logic [63:0]   light_regs [8];
   color_type     color_queue [$];
   int            error_count;
   bit            burst_mode;
   bit            hold_rsp;
   point_row_type dir_rows [12];

   point_light_phong_shading_top #(.LIGHT_RANGE(LIGHT_RANGE), .SHININESS(SHININESS)) i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint unsigned isqrt(input longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint limit_q14(input longint q);
      if (q > ONE_Q14) return ONE_Q14;
      if (q < -ONE_Q14) return -ONE_Q14;
      return q;
   endfunction

   function automatic longint norm_vec(input longint cx, cy, cz,
                                       output longint ux, uy, uz);
      longint unsigned s;
      longint len;
      s = longint'(cx * cx) + longint'(cy * cy) + longint'(cz * cz);
      len = longint'(isqrt(s << 16));
      ux = 0;
      uy = 0;
      uz = 0;
      if (len != 0) begin
         ux = limit_q14((cx * 4194304) / len);
         uy = limit_q14((cy * 4194304) / len);
         uz = limit_q14((cz * 4194304) / len);
      end
      return len;
   endfunction

   function automatic longint unsigned term_q14(input longint p);
      longint unsigned t;
      if (p <= 0) return 0;
      t = longint'(p) >>> 14;
      return (t > ONE_Q14) ? ONE_Q14 : t;
   endfunction

   function automatic longint sx(input logic [15:0] v);
      return longint'($signed(v));
   endfunction

   function automatic color_type shade_point(input logic [15:0] nx, ny, nz, px, py, pz);
      longint lx, ly, lz, vx, vy, vz, rx, ry, rz, bx, by, bz;
      longint light_len, ndl, dummy;
      longint unsigned diff, base, spec, att, str, rq, ci, ii, c;
      logic [15:0] ch [3];
      color_type res;
      light_len = norm_vec(sx(light_regs[REG_LIGHT_X][15:0]) - sx(px),
                           sx(light_regs[REG_LIGHT_Y][15:0]) - sx(py),
                           sx(light_regs[REG_LIGHT_Z][15:0]) - sx(pz), lx, ly, lz);
      dummy = norm_vec(sx(light_regs[REG_CAMERA_X][15:0]) - sx(px),
                       sx(light_regs[REG_CAMERA_Y][15:0]) - sx(py),
                       sx(light_regs[REG_CAMERA_Z][15:0]) - sx(pz), vx, vy, vz);
      ndl = sx(nx) * lx + sx(ny) * ly + sx(nz) * lz;
      diff = term_q14(ndl);
      bx = (-lx * 268435456 + 2 * ndl * sx(nx)) / 268435456;
      by = (-ly * 268435456 + 2 * ndl * sx(ny)) / 268435456;
      bz = (-lz * 268435456 + 2 * ndl * sx(nz)) / 268435456;
      dummy = norm_vec(bx, by, bz, rx, ry, rz);
      base = term_q14(vx * rx + vy * ry + vz * rz);
      spec = ONE_Q14;
      for (int k = 0; k < SHININESS; k++) spec = (spec * base) >> 14;
      rq = 64'(LIGHT_RANGE) << 16;
      att = 0;
      if (unsigned'(light_len) < rq) att = ((rq - unsigned'(light_len)) * ONE_Q14) / rq;
      str = diff + spec;
      for (int k = 0; k < 3; k++) begin
         ci = (light_regs[REG_COLOR] >> (32 - 16 * k)) & 64'hFFFF;
         ii = (light_regs[REG_INTENSITY] >> (32 - 16 * k)) & 64'hFFFF;
         c = (((ci * ii) * str) * att) >> 44;
         ch[k] = (c > 64'hFFFF) ? 16'hFFFF : c[15:0];
      end
      res.red = ch[0];
      res.green = ch[1];
      res.blue = ch[2];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got, exp_v);
      $display("mismatch %s: got %h, expected %h at %0t", what, got, exp_v, $realtime);
      error_count++;
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 6'(8 * idx);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      light_regs[idx] = (idx < REG_INTENSITY) ? (value & 64'hFFFF) : (value & 64'hFFFF_FFFF_FFFF);
   endtask

   task automatic load_light(input logic [15:0] lx, ly, lz, cx, cy, cz,
                             input logic [47:0] inten, col);
      write_csr(REG_LIGHT_X, {48'd0, lx});
      write_csr(REG_LIGHT_Y, {48'd0, ly});
      write_csr(REG_LIGHT_Z, {48'd0, lz});
      write_csr(REG_CAMERA_X, {48'd0, cx});
      write_csr(REG_CAMERA_Y, {48'd0, cy});
      write_csr(REG_CAMERA_Z, {48'd0, cz});
      write_csr(REG_INTENSITY, {16'd0, inten});
      write_csr(REG_COLOR, {16'd0, col});
   endtask

   task automatic send_point(input point_row_type row);
      int gap;
      color_type exp_c;
      gap = burst_mode ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {row.pz, row.py, row.px, row.nz, row.ny, row.nx};
      do @(posedge clock); while (!req_tready);
      exp_c = row.typed ? row.color : shade_point(row.nx, row.ny, row.nz, row.px, row.py, row.pz);
      color_queue = {color_queue, exp_c};
   endtask

   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (color_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_normal();
      case ($urandom_range(0, 9))
         0: return 16'h8000 | 16'($urandom_range(0, 65535));
         1: return 16'(ONE_Q14);
         2: return 16'(-ONE_Q14);
         default: return 16'($urandom_range(0, 32768) - ONE_Q14);
      endcase
   endfunction

   function automatic logic [15:0] rand_coord(input logic [15:0] center);
      if ($urandom_range(0, 4) == 0) return 16'($urandom_range(0, 65535));
      return center + 16'($urandom_range(0, 10000)) - 16'd5000;
   endfunction

   task automatic random_phase(input int count);
      point_row_type row;
      for (int i = 0; i < count; i++) begin
         row.nx = rand_normal();
         row.ny = rand_normal();
         row.nz = rand_normal();
         row.px = rand_coord(light_regs[REG_LIGHT_X][15:0]);
         row.py = rand_coord(light_regs[REG_LIGHT_Y][15:0]);
         row.pz = rand_coord(light_regs[REG_LIGHT_Z][15:0]);
         if ($urandom_range(0, 19) == 0) begin
            row.px = light_regs[REG_LIGHT_X][15:0];
            row.py = light_regs[REG_LIGHT_Y][15:0];
            row.pz = light_regs[REG_LIGHT_Z][15:0];
         end
         row.typed = 1'b0;
         row.color = '0;
         send_point(row);
      end
   endtask

   function automatic logic [47:0] rand48();
      return {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535))};
   endfunction

   always @(posedge clock) begin
      color_type got, exp_c;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (color_queue.size() == 0) begin
            report_mismatch("unexpected item", got.red, 16'd0);
         end else begin
            exp_c = color_queue.pop_front();
            if (got.red !== exp_c.red) report_mismatch("red_out", got.red, exp_c.red);
            if (got.green !== exp_c.green) report_mismatch("green_out", got.green, exp_c.green);
            if (got.blue !== exp_c.blue) report_mismatch("blue_out", got.blue, exp_c.blue);
         end
      end
   end

   initial begin
      int stall;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
         stall = burst_mode ? 0 : $urandom_range(0, 8);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready) && !hold_rsp);
      end
   end

   initial begin
      #2ms;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      error_count = 0;
      burst_mode = 1'b0;
      hold_rsp = 1'b0;
      for (int k = 0; k < 8; k++) light_regs[k] = '0;
      // zero color after reset: every result is zero, including a zero-length direction
      dir_rows[0]  = '{16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, '0};
      dir_rows[1]  = '{16'hC000, 16'hC000, 16'hC000, 16'h8000, 16'h8000, 16'h8000, 1'b1, '0};
      dir_rows[2]  = '{16'h8000, 16'h7FFF, 16'h4000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, '0};
      dir_rows[3]  = '{16'h0000, 16'h0000, 16'h4000, 16'h0500, 16'h0000, 16'h0000, 1'b0, '0};
      // light at z = 5, camera at z = 10
      dir_rows[4]  = '{16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0500, 1'b0, '0};
      dir_rows[5]  = '{16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0};
      dir_rows[6]  = '{16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0};
      dir_rows[7]  = '{16'h4000, 16'h4000, 16'h4000, 16'h0100, 16'h0000, 16'h0000, 1'b0, '0};
      dir_rows[8]  = '{16'h4000, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 1'b0, '0};
      dir_rows[9]  = '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, '0};
      dir_rows[10] = '{16'h2D41, 16'h0000, 16'h2D41, 16'h0300, 16'h0000, 16'h0000, 1'b0, '0};
      dir_rows[11] = '{16'h0000, 16'h4000, 16'h0000, 16'hFF00, 16'h0200, 16'h0400, 1'b0, '0};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < 12; i++) begin
         if (i == 4) begin
            drain_pipeline();
            load_light(16'h0000, 16'h0000, 16'h0500, 16'h0000, 16'h0000, 16'h0A00,
                       48'h4000_4000_4000, 48'h4000_4000_4000);
         end
         send_point(dir_rows[i]);
      end
      for (int ph = 0; ph < 8; ph++) begin
         drain_pipeline();
         case (ph)
            0: load_light(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000,
                          48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
            1: load_light(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                          48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF);
            default: load_light(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                                rand48(), rand48());
         endcase
         burst_mode = (ph == 3 || ph == 6);
         hold_rsp = (ph == 2 || ph == 5);
         random_phase(56);
      end
      drain_pipeline();
      if (error_count == 0 && color_queue.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
`default_nettype wire
